### design/bcc_pkg.sv
// Shared types and constants for the button click classifier.
`default_nettype none

package bcc_pkg;

    localparam logic [31:0] DEBOUNCE_MS = 32'd50;

    localparam logic [15:0] LONG_CLICK_RST   = 16'd1000;
    localparam logic [15:0] DOUBLE_CLICK_RST = 16'd300;

    // register index, taken from paddr[2]
    localparam logic REG_LONG_CLICK   = 1'b0;
    localparam logic REG_DOUBLE_CLICK = 1'b1;

    localparam int FLAG_LOW_BIT      = 0;
    localparam int FLAG_HIGH_BIT     = 1;
    localparam int FLAG_PRESSED_BIT  = 2;
    localparam int FLAG_RELEASED_BIT = 3;
    localparam int FLAG_DOUBLE_BIT   = 4;
    localparam int FLAG_LONG_BIT     = 5;

    typedef logic [5:0] flags_t;

    localparam flags_t FLAG_LOW      = 6'b000001;
    localparam flags_t FLAG_HIGH     = 6'b000010;
    localparam flags_t FLAG_PRESSED  = 6'b000100;
    localparam flags_t FLAG_RELEASED = 6'b001000;
    localparam flags_t FLAG_DOUBLE   = 6'b010000;
    localparam flags_t FLAG_LONG     = 6'b100000;

    typedef logic [1:0] event_t;

    localparam event_t EV_NONE   = 2'd0;
    localparam event_t EV_LONG   = 2'd1;
    localparam event_t EV_SINGLE = 2'd2;
    localparam event_t EV_DOUBLE = 2'd3;

    typedef struct packed {
        logic [15:0] long_click_ms;
        logic [15:0] double_click_ms;
    } bcc_cfg_t;

endpackage

`default_nettype wire

### design/bcc_cfg.sv
// APB register file for the click timing settings.
`default_nettype none

module bcc_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output bcc_pkg::bcc_cfg_t      cfg
);
    import bcc_pkg::*;

    logic [15:0] long_click_reg;
    logic [15:0] double_click_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_click_reg   <= LONG_CLICK_RST;
            double_click_reg <= DOUBLE_CLICK_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_LONG_CLICK)
                long_click_reg <= pwdata[15:0];
            else
                double_click_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_LONG_CLICK)
            prdata = {16'b0, long_click_reg};
        else
            prdata = {16'b0, double_click_reg};
    end

    assign cfg.long_click_ms   = long_click_reg;
    assign cfg.double_click_ms = double_click_reg;

endmodule

`default_nettype wire

### design/bcc_core.sv
// Button state registers and the per-poll classification logic.
`default_nettype none

module bcc_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              pin_level,
    input  wire logic [31:0]       now_ms,
    input  wire bcc_pkg::bcc_cfg_t cfg,
    output bcc_pkg::event_t        click_event,
    output logic                   led_on
);
    import bcc_pkg::*;

    flags_t      flags_reg, flags_next;
    logic [31:0] change_time_reg, change_time_next;
    logic [31:0] press_time_reg, press_time_next;
    logic        led_reg, led_next;

    flags_t      work_flags;
    logic [31:0] debounce_edge;
    logic [31:0] long_end;
    logic [31:0] double_end;
    logic        bounce;
    logic        long_due;
    logic        double_due;

    // all compares are unsigned and wrap modulo 2^32
    assign debounce_edge = now_ms - DEBOUNCE_MS;
    assign long_end      = press_time_reg + {16'b0, cfg.long_click_ms};
    assign double_end    = press_time_reg + {16'b0, cfg.double_click_ms};
    assign bounce        = change_time_reg > debounce_edge;
    assign long_due      = long_end < now_ms;
    assign double_due    = double_end < now_ms;

    always_comb
    begin
        flags_next       = flags_reg;
        change_time_next = change_time_reg;
        press_time_next  = press_time_reg;
        led_next         = led_reg;
        click_event      = EV_NONE;
        work_flags       = flags_reg;

        if (pin_level)
        begin
            if (flags_reg[FLAG_HIGH_BIT] || !bounce)
            begin
                led_next         = 1'b1;
                change_time_next = now_ms;
                if (!flags_reg[FLAG_HIGH_BIT])
                begin
                    flags_next      = flags_reg[FLAG_RELEASED_BIT] ? (FLAG_HIGH | FLAG_DOUBLE)
                                                                   : (FLAG_HIGH | FLAG_PRESSED);
                    press_time_next = now_ms;
                end
                else if (flags_reg[FLAG_PRESSED_BIT] && long_due)
                begin
                    // repeats every long-click period while held
                    flags_next      = flags_reg | FLAG_LONG;
                    press_time_next = now_ms;
                    click_event     = EV_LONG;
                end
            end
        end
        else if (flags_reg != FLAG_LOW && (flags_reg[FLAG_LOW_BIT] || !bounce))
        begin
            led_next         = 1'b0;
            change_time_next = now_ms;
            if (work_flags[FLAG_DOUBLE_BIT])
            begin
                work_flags  = FLAG_LOW;
                click_event = EV_DOUBLE;
            end
            if (work_flags[FLAG_LONG_BIT])
                work_flags = FLAG_LOW;
            if (work_flags[FLAG_PRESSED_BIT])
                work_flags = FLAG_LOW | FLAG_RELEASED;
            if (work_flags[FLAG_RELEASED_BIT] && double_due)
            begin
                work_flags  = FLAG_LOW;
                click_event = EV_SINGLE;
            end
            if (!work_flags[FLAG_LOW_BIT])
                work_flags = FLAG_LOW;
            flags_next = work_flags;
        end
    end

    assign led_on = led_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg       <= FLAG_LOW;
            change_time_reg <= 32'd0;
            press_time_reg  <= 32'd0;
            led_reg         <= 1'b0;
        end
        else if (en)
        begin
            flags_reg       <= flags_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
            led_reg         <= led_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_flags_level: assert property (@(posedge clk) disable iff (!rst_n)
        !(flags_reg[FLAG_LOW_BIT] && flags_reg[FLAG_HIGH_BIT]))
        else $error("button flags hold both levels");

    a_long_led: assert property (@(posedge clk) disable iff (!rst_n)
        (en && click_event == EV_LONG) |=> (led_reg && flags_reg[FLAG_LONG_BIT]))
        else $error("long click without held button");

    a_release_led: assert property (@(posedge clk) disable iff (!rst_n)
        (en && (click_event == EV_DOUBLE || click_event == EV_SINGLE))
            |=> (!led_reg && flags_reg == FLAG_LOW))
        else $error("click reported without release");
`endif

endmodule

`default_nettype wire

### design/button_click_classifier.sv
// The input word is held in the input stage register and its result word in the
// output stage register. Throughput: one word per cycle while m_tready is held;
// the button state update is combinational compares on the state registers, so
// polls follow back to back. Input and output registers hold the words; s_tready
// follows m_tready combinationally while both stages are full.
// Reset (rst_n, async, active low): flags LOW, times and LED zero,
// long_click_ms 1000, double_click_ms 300, both stages empty.
`default_nettype none

module button_click_classifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [1:0] click_event, [2] led_on, [7:3] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import bcc_pkg::*;

    bcc_cfg_t    cfg;
    logic        in_valid_reg;
    logic        pin_reg;
    logic [31:0] now_reg;
    logic        out_valid_reg;
    event_t      event_reg;
    logic        led_out_reg;
    event_t      core_event;
    logic        core_led;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    bcc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .pin_level   (pin_reg),
        .now_ms      (now_reg),
        .cfg         (cfg),
        .click_event (core_event),
        .led_on      (core_led)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pin_reg <= s_tdata[0];
            now_reg <= s_tdata[32:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg   <= core_event;
            led_out_reg <= core_led;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, led_out_reg, event_reg};

`ifndef NO_ASSERTIONS
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed word did not reach the output stage");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(now_reg) && $stable(pin_reg)))
        else $error("stalled input stage lost its word");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are full");
`endif

endmodule

`default_nettype wire
